### hw/rtl/pcv_pkg.sv
`default_nettype none

package pcv_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 20;
    localparam int CHAN_W              = 8;
    localparam int THRESH_W            = 16;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd42894;

    // Output field widths are fixed whatever the tally width.
    localparam int FIELD_W   = 20;
    localparam int VERDICT_W = 2;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 64;

    localparam int SQ_W    = 2 * CHAN_W;
    localparam int SUMSQ_W = SQ_W + 2;
    localparam int PROD_W  = THRESH_W + SUMSQ_W;

    localparam logic [VERDICT_W-1:0] VERDICT_NONE  = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_BLUE  = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_GREEN = 2'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_RED   = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_MULT,
        ST_TALLY
    } pcv_state_t;

    typedef struct packed {
        logic load;
        logic square;
        logic multiply;
        logic update;
    } pcv_cmd_t;

    typedef struct packed {
        logic last;
        logic out_free;
    } pcv_status_t;

endpackage

`default_nettype wire

### hw/rtl/pcv_ctrl.sv
`default_nettype none

module pcv_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  pcv_pkg::pcv_status_t status,
    output pcv_pkg::pcv_cmd_t   cmd
);

    pcv_pkg::pcv_state_t state_reg;
    pcv_pkg::pcv_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcv_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pcv_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = pcv_pkg::ST_SQUARE;
                end
            end
            pcv_pkg::ST_SQUARE:
            begin
                state_next = pcv_pkg::ST_MULT;
            end
            pcv_pkg::ST_MULT:
            begin
                state_next = pcv_pkg::ST_TALLY;
            end
            pcv_pkg::ST_TALLY:
            begin
                // A frame's last pixel waits here until the result register is free.
                if (!status.last || status.out_free)
                begin
                    state_next = pcv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pcv_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            pcv_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            pcv_pkg::ST_SQUARE:
            begin
                cmd.square = 1'b1;
            end
            pcv_pkg::ST_MULT:
            begin
                cmd.multiply = 1'b1;
            end
            pcv_pkg::ST_TALLY:
            begin
                cmd.update = !status.last || status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef SYNTH
    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == pcv_pkg::ST_SQUARE)
        else $error("pixel load did not start the squaring step");

    a_update_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> s_tready)
        else $error("tally update did not return the controller to idle");

    a_last_needs_space: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update && status.last |-> status.out_free)
        else $error("frame result written while the output register was occupied");
`endif

endmodule

`default_nettype wire

### hw/rtl/pcv_datapath.sv
`default_nettype none

module pcv_datapath #(
    parameter int COUNT_WIDTH = pcv_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire  [pcv_pkg::S_DATA_W-1:0]     s_tdata,
    input  wire                              s_tlast,
    input  wire                              cfg_wr_en,
    input  wire  [pcv_pkg::THRESH_W-1:0]     cfg_wr_data,
    input  pcv_pkg::pcv_cmd_t                cmd,
    output pcv_pkg::pcv_status_t             status,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [pcv_pkg::M_DATA_W-1:0]     m_tdata
);

    localparam logic [COUNT_WIDTH-1:0] TALLY_MAX = '1;

    logic [pcv_pkg::THRESH_W-1:0] thresh_reg;

    logic [pcv_pkg::CHAN_W-1:0]   blue_reg;
    logic [pcv_pkg::CHAN_W-1:0]   green_reg;
    logic [pcv_pkg::CHAN_W-1:0]   red_reg;
    logic                         last_reg;

    logic [pcv_pkg::SQ_W-1:0]     blue_sq_reg;
    logic [pcv_pkg::SQ_W-1:0]     green_sq_reg;
    logic [pcv_pkg::SQ_W-1:0]     red_sq_reg;
    logic [pcv_pkg::SUMSQ_W-1:0]  sumsq_reg;
    logic [pcv_pkg::PROD_W-1:0]   prod_reg;

    logic [COUNT_WIDTH-1:0]       blue_tally_reg;
    logic [COUNT_WIDTH-1:0]       green_tally_reg;
    logic [COUNT_WIDTH-1:0]       red_tally_reg;
    logic [COUNT_WIDTH-1:0]       blue_tally_next;
    logic [COUNT_WIDTH-1:0]       green_tally_next;
    logic [COUNT_WIDTH-1:0]       red_tally_next;

    logic                         out_valid_reg;
    logic [pcv_pkg::FIELD_W-1:0]  blue_out_reg;
    logic [pcv_pkg::FIELD_W-1:0]  green_out_reg;
    logic [pcv_pkg::FIELD_W-1:0]  red_out_reg;
    logic [pcv_pkg::VERDICT_W-1:0] verdict_out_reg;
    logic [pcv_pkg::VERDICT_W-1:0] verdict_next;

    logic                         blue_hit;
    logic                         green_hit;
    logic                         red_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= pcv_pkg::THRESH_RESET;
        end
        else if (cfg_wr_en)
        begin
            thresh_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            blue_reg  <= s_tdata[7:0];
            green_reg <= s_tdata[15:8];
            red_reg   <= s_tdata[23:16];
            last_reg  <= s_tlast;
        end
        if (cmd.square)
        begin
            blue_sq_reg  <= pcv_pkg::SQ_W'(blue_reg * blue_reg);
            green_sq_reg <= pcv_pkg::SQ_W'(green_reg * green_reg);
            red_sq_reg   <= pcv_pkg::SQ_W'(red_reg * red_reg);
            sumsq_reg    <= pcv_pkg::SUMSQ_W'(blue_reg * blue_reg)
                          + pcv_pkg::SUMSQ_W'(green_reg * green_reg)
                          + pcv_pkg::SUMSQ_W'(red_reg * red_reg);
        end
        if (cmd.multiply)
        begin
            prod_reg <= pcv_pkg::PROD_W'(thresh_reg) * pcv_pkg::PROD_W'(sumsq_reg);
        end
    end

    // The channel square scaled by 2^16 is compared with threshold times the sum of squares.
    always_comb
    begin
        blue_hit  = pcv_pkg::PROD_W'({blue_sq_reg, 16'd0}) > prod_reg;
        green_hit = pcv_pkg::PROD_W'({green_sq_reg, 16'd0}) > prod_reg;
        red_hit   = pcv_pkg::PROD_W'({red_sq_reg, 16'd0}) > prod_reg;

        blue_tally_next  = blue_tally_reg;
        green_tally_next = green_tally_reg;
        red_tally_next   = red_tally_reg;
        if (blue_hit && blue_tally_reg != TALLY_MAX)
        begin
            blue_tally_next = blue_tally_reg + 1'b1;
        end
        if (green_hit && green_tally_reg != TALLY_MAX)
        begin
            green_tally_next = green_tally_reg + 1'b1;
        end
        if (red_hit && red_tally_reg != TALLY_MAX)
        begin
            red_tally_next = red_tally_reg + 1'b1;
        end

        if (blue_tally_next > green_tally_next && blue_tally_next > red_tally_next)
        begin
            verdict_next = pcv_pkg::VERDICT_BLUE;
        end
        else if (green_tally_next > blue_tally_next && green_tally_next > red_tally_next)
        begin
            verdict_next = pcv_pkg::VERDICT_GREEN;
        end
        else if (red_tally_next > blue_tally_next && red_tally_next > green_tally_next)
        begin
            verdict_next = pcv_pkg::VERDICT_RED;
        end
        else
        begin
            verdict_next = pcv_pkg::VERDICT_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blue_tally_reg  <= '0;
            green_tally_reg <= '0;
            red_tally_reg   <= '0;
        end
        else if (cmd.update)
        begin
            if (last_reg)
            begin
                blue_tally_reg  <= '0;
                green_tally_reg <= '0;
                red_tally_reg   <= '0;
            end
            else
            begin
                blue_tally_reg  <= blue_tally_next;
                green_tally_reg <= green_tally_next;
                red_tally_reg   <= red_tally_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.update && last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update && last_reg)
        begin
            blue_out_reg    <= pcv_pkg::FIELD_W'(blue_tally_next);
            green_out_reg   <= pcv_pkg::FIELD_W'(green_tally_next);
            red_out_reg     <= pcv_pkg::FIELD_W'(red_tally_next);
            verdict_out_reg <= verdict_next;
        end
    end

    always_comb
    begin
        status.last     = last_reg;
        status.out_free = !out_valid_reg || m_tready;
        m_tvalid        = out_valid_reg;
        m_tdata         = {2'b00, verdict_out_reg, red_out_reg, green_out_reg, blue_out_reg};
    end

`ifndef SYNTH
    a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update && last_reg |=> blue_tally_reg == '0 && green_tally_reg == '0
            && red_tally_reg == '0)
        else $error("tallies not cleared after the last pixel of a frame");

    a_tally_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.update && last_reg) |=> blue_tally_reg >= $past(blue_tally_reg)
            && green_tally_reg >= $past(green_tally_reg)
            && red_tally_reg >= $past(red_tally_reg))
        else $error("a tally fell within a frame");

    a_result_raised: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update && last_reg |=> m_tvalid)
        else $error("frame result not presented after the last pixel");
`endif

endmodule

`default_nettype wire

### hw/rtl/pixel_colour_vote_classifier.sv
// A frame result is raised on the master side when its last pixel completes the tally step.
// Each pixel passes load, square, multiply and tally steps of a single shared datapath
// before the next pixel is taken.
// A last pixel holds in the tally step while an earlier result is still waiting.
// Reset (rst_n, asynchronous, active low) clears the tallies and the result valid flag and
// loads the threshold with cos squared of pi/5.
`default_nettype none

module pixel_colour_vote_classifier #(
    parameter int COUNT_WIDTH = pcv_pkg::COUNT_WIDTH_DEFAULT
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    // blue [7:0], green [15:8], red [23:16]
    input  wire  [pcv_pkg::S_DATA_W-1:0] s_tdata,
    input  wire                          s_tlast,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    // blue_count [19:0], green_count [39:20], red_count [59:40], verdict [61:60], zero [63:62]
    output logic [pcv_pkg::M_DATA_W-1:0] m_tdata,
    input  wire                          cfg_wr_en,
    input  wire  [pcv_pkg::THRESH_W-1:0] cfg_wr_data
);

    pcv_pkg::pcv_cmd_t    cmd;
    pcv_pkg::pcv_status_t status;

    pcv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pcv_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire
